>>> hw/rtl/text_console_cursor_scroll_unit_macros.svh
// assertion helpers used by the console datapath
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define TCSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcsu assertion failed");

// next-cycle implication, masked during reset
`define TCSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcsu assertion failed");

`endif

>>> hw/rtl/tcsu_pkg.sv
`default_nettype none

package tcsu_pkg;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = ROWS * COLS;

    // cell store index, wide enough to hold CELLS itself
    localparam int IDX_W      = $clog2(CELLS + 1);
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int READ_IDX_W = 11;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int ATTR_W     = 2 * COLOR_W;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    typedef enum logic [1:0] {
        OP_PRINT = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FG = 1'd0,
        REG_BG = 1'd1
    } t_reg;

    typedef enum logic [1:0] {
        WR_CHAR  = 2'd0,
        WR_COPY  = 2'd1,
        WR_BLANK = 2'd2
    } t_wr_sel;

    typedef enum logic {
        RD_INDEX = 1'b0,
        RD_COPY  = 1'b1
    } t_rd_sel;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    home;
        logic    next_line;
        logic    col_zero;
        logic    col_inc;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    load_out;
        logic    cell_from_mem;
        logic    keep_cell;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic is_newline;
        logic col_at_end;
        logic last_row;
        logic idx_in_range;
        logic cnt_zero;
        logic cnt_copy_end;
        logic cnt_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/tcsu_ctrl.sv
`default_nettype none

module tcsu_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire tcsu_pkg::t_status i_status,
    output tcsu_pkg::t_cmd         o_cmd,
    output logic                   o_in_stall
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_SCOPY  = 7'b0000100,
        S_SBLANK = 7'b0001000,
        S_SCLEAR = 7'b0010000,
        S_RWAIT  = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_status.op)
                    tcsu_pkg::OP_PRINT: begin
                        if (i_status.is_newline) begin
                            if (i_status.last_row) begin
                                o_cmd.col_zero = 1'b1;
                                o_cmd.cnt_clr  = 1'b1;
                                n_state        = S_SCOPY;
                            end else begin
                                o_cmd.next_line = 1'b1;
                                o_cmd.load_out  = i_status.out_free;
                                n_state         = i_status.out_free ? S_IDLE : S_FIN;
                            end
                        end else if (i_status.col_at_end) begin
                            // pending wrap: line feed first, then write on return
                            if (i_status.last_row) begin
                                o_cmd.col_zero = 1'b1;
                                o_cmd.cnt_clr  = 1'b1;
                                n_state        = S_SCOPY;
                            end else begin
                                o_cmd.next_line = 1'b1;
                            end
                        end else begin
                            o_cmd.wr_en    = 1'b1;
                            o_cmd.wr_sel   = tcsu_pkg::WR_CHAR;
                            o_cmd.col_inc  = 1'b1;
                            o_cmd.load_out = i_status.out_free;
                            n_state        = i_status.out_free ? S_IDLE : S_FIN;
                        end
                    end
                    tcsu_pkg::OP_CLEAR: begin
                        o_cmd.home    = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_SCLEAR;
                    end
                    tcsu_pkg::OP_READ: begin
                        if (i_status.idx_in_range) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = tcsu_pkg::RD_INDEX;
                            n_state      = S_RWAIT;
                        end else begin
                            o_cmd.load_out = i_status.out_free;
                            n_state        = i_status.out_free ? S_IDLE : S_FIN;
                        end
                    end
                    default: begin
                        o_cmd.load_out = i_status.out_free;
                        n_state        = i_status.out_free ? S_IDLE : S_FIN;
                    end
                endcase
            end
            S_SCOPY: begin
                o_cmd.rd_en  = !i_status.cnt_copy_end;
                o_cmd.rd_sel = tcsu_pkg::RD_COPY;
                o_cmd.wr_en  = !i_status.cnt_zero;
                o_cmd.wr_sel = tcsu_pkg::WR_COPY;
                if (i_status.cnt_copy_end) begin
                    n_state = S_SBLANK;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_SBLANK: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = tcsu_pkg::WR_BLANK;
                if (i_status.cnt_last) begin
                    if (i_status.is_newline) begin
                        o_cmd.load_out = i_status.out_free;
                        n_state        = i_status.out_free ? S_IDLE : S_FIN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_SCLEAR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = tcsu_pkg::WR_BLANK;
                if (i_status.cnt_last) begin
                    o_cmd.load_out = i_status.out_free;
                    n_state        = i_status.out_free ? S_IDLE : S_FIN;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_RWAIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out      = 1'b1;
                    o_cmd.cell_from_mem = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    o_cmd.keep_cell = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/tcsu_dpath.sv
`default_nettype none
`include "text_console_cursor_scroll_unit_macros.svh"

module tcsu_dpath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr,
    input  wire logic [tcsu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [tcsu_pkg::COLOR_W-1:0]         i_cfg_data,
    input  wire logic [1:0]                           i_opcode,
    input  wire logic [tcsu_pkg::CHAR_W-1:0]          i_character,
    input  wire logic [tcsu_pkg::READ_IDX_W-1:0]      i_read_index,
    input  wire logic                                 i_out_stall,
    input  wire tcsu_pkg::t_cmd                       i_cmd,
    output tcsu_pkg::t_status                         o_status,
    output logic                                      o_out_valid,
    output logic [tcsu_pkg::CHAR_W-1:0]               o_cell_character,
    output logic [tcsu_pkg::ATTR_W-1:0]               o_cell_attribute,
    output logic [tcsu_pkg::ROW_W-1:0]                o_cursor_row,
    output logic [tcsu_pkg::COL_W-1:0]                o_cursor_column
);

    localparam int IDX_W = tcsu_pkg::IDX_W;
    localparam logic [tcsu_pkg::COL_W-1:0] COL_END  = tcsu_pkg::COL_W'(tcsu_pkg::COLS);
    localparam logic [tcsu_pkg::ROW_W-1:0] ROW_LAST = tcsu_pkg::ROW_W'(tcsu_pkg::ROWS - 1);

    logic [tcsu_pkg::COLOR_W-1:0]    r_fg;
    logic [tcsu_pkg::COLOR_W-1:0]    r_bg;
    tcsu_pkg::t_op                   r_op;
    logic [tcsu_pkg::CHAR_W-1:0]     r_char;
    logic [tcsu_pkg::READ_IDX_W-1:0] r_ridx;
    logic [tcsu_pkg::ROW_W-1:0]      r_row;
    logic [tcsu_pkg::ROW_W-1:0]      n_row;
    logic [tcsu_pkg::COL_W-1:0]      r_col;
    logic [tcsu_pkg::COL_W-1:0]      n_col;
    logic [IDX_W-1:0]                r_cnt;
    logic [IDX_W-1:0]                n_cnt;
    logic [tcsu_pkg::CELL_W-1:0]     r_cell;
    logic                            r_out_valid;

    logic [tcsu_pkg::CELL_W-1:0]     r_mem [tcsu_pkg::CELLS];
    logic [tcsu_pkg::CELL_W-1:0]     r_rdata;

    logic [tcsu_pkg::ATTR_W-1:0]     w_attr;
    logic [IDX_W-1:0]                w_char_addr;
    logic [IDX_W-1:0]                w_wr_addr;
    logic [tcsu_pkg::CELL_W-1:0]     w_wr_data;
    logic [IDX_W-1:0]                w_rd_addr;
    logic [tcsu_pkg::CELL_W-1:0]     w_out_cell;
    logic                            w_out_free;
    logic                            w_char_wr;

    // colour registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcsu_pkg::FG_RESET;
            r_bg <= tcsu_pkg::BG_RESET;
        end else if (i_cfg_wr) begin
            case (tcsu_pkg::t_reg'(i_cfg_index))
                tcsu_pkg::REG_FG: r_fg <= i_cfg_data;
                tcsu_pkg::REG_BG: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_attr = {r_bg, r_fg};

    // captured transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= tcsu_pkg::t_op'(i_opcode);
            r_char <= i_character;
            r_ridx <= i_read_index;
        end
    end

    // cursor and sweep counter
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_cmd.home) begin
            n_row = '0;
            n_col = '0;
        end
        if (i_cmd.next_line) begin
            n_row = r_row + 1'b1;
            n_col = '0;
        end
        if (i_cmd.col_zero) begin
            n_col = '0;
        end
        if (i_cmd.col_inc) begin
            n_col = r_col + 1'b1;
        end
        n_cnt = r_cnt;
        if (i_cmd.cnt_clr) begin
            n_cnt = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_cnt <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_cnt <= n_cnt;
        end
    end

    // cell store ports
    assign w_char_addr = IDX_W'(32'(r_row) * tcsu_pkg::COLS + 32'(r_col));

    always_comb begin
        case (i_cmd.wr_sel)
            tcsu_pkg::WR_CHAR: begin
                w_wr_addr = w_char_addr;
                w_wr_data = {w_attr, r_char};
            end
            tcsu_pkg::WR_COPY: begin
                // row move: the registered read of the previous count is written one row up
                w_wr_addr = r_cnt - 1'b1;
                w_wr_data = r_rdata;
            end
            tcsu_pkg::WR_BLANK: begin
                w_wr_addr = r_cnt;
                w_wr_data = {w_attr, tcsu_pkg::BLANK_CHAR};
            end
            default: begin
                w_wr_addr = r_cnt;
                w_wr_data = {w_attr, tcsu_pkg::BLANK_CHAR};
            end
        endcase
        case (i_cmd.rd_sel)
            tcsu_pkg::RD_INDEX: w_rd_addr = IDX_W'(r_ridx);
            tcsu_pkg::RD_COPY:  w_rd_addr = r_cnt + IDX_W'(tcsu_pkg::COLS);
            default:            w_rd_addr = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cell <= '0;
        end else if (i_cmd.keep_cell) begin
            r_cell <= r_rdata;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_cell = i_cmd.cell_from_mem ? r_rdata : r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_cell_character <= w_out_cell[tcsu_pkg::CHAR_W-1:0];
            o_cell_attribute <= w_out_cell[tcsu_pkg::CELL_W-1:tcsu_pkg::CHAR_W];
            o_cursor_row     <= n_row;
            o_cursor_column  <= n_col;
        end
    end

    assign o_out_valid = r_out_valid;

    // status back to the controller
    assign o_status.op           = r_op;
    assign o_status.is_newline   = (r_char == tcsu_pkg::NEWLINE_CHAR);
    assign o_status.col_at_end   = (r_col >= COL_END);
    assign o_status.last_row     = (r_row == ROW_LAST);
    assign o_status.idx_in_range = (32'(r_ridx) < tcsu_pkg::CELLS);
    assign o_status.cnt_zero     = (r_cnt == '0);
    assign o_status.cnt_copy_end = (r_cnt == IDX_W'(tcsu_pkg::CELLS - tcsu_pkg::COLS));
    assign o_status.cnt_last     = (r_cnt == IDX_W'(tcsu_pkg::CELLS - 1));
    assign o_status.out_free     = w_out_free;

    assign w_char_wr = i_cmd.wr_en && (i_cmd.wr_sel == tcsu_pkg::WR_CHAR);

    `TCSU_ASSERT_NOW(a_col_range, i_clk, i_rst_n, 1'b1, r_col <= COL_END)
    `TCSU_ASSERT_NOW(a_row_range, i_clk, i_rst_n, 1'b1, r_row <= ROW_LAST)
    `TCSU_ASSERT_NOW(a_char_wr_in_line, i_clk, i_rst_n, w_char_wr, r_col < COL_END)
    `TCSU_ASSERT_NOW(a_no_result_overwrite, i_clk, i_rst_n, i_cmd.load_out, w_out_free)
    `TCSU_ASSERT_NEXT(a_capture_then_busy, i_clk, i_rst_n, i_cmd.capture, !i_cmd.capture)

endmodule

`default_nettype wire

>>> hw/rtl/text_console_cursor_scroll_unit.sv
// text console engine: a 25 x 80 store of 16-bit cells (character in the low byte, colour
// attribute in the high byte) plus a cursor. each transaction on the input channel carries an
// opcode (print, clear, read, or no-op) and gives exactly one result transaction carrying the
// read cell (zero for anything but an in-range read) and the cursor after the operation; a
// cursor column of 80 means a wrap is pending. colours come from two config registers
// (index 0 foreground, index 1 background); they take a write in any cycle and colour every
// cell written after it, so change them only while no transaction is in flight. the cell
// store has one read and one write port and is swept by a counter: a clear writes one blank
// cell per cycle, and a print or newline that scrolls moves one cell up per cycle, then writes
// one blank per cycle for the bottom row. input is stalled while an item is being worked on;
// a finished result may wait in the output register while the next item is taken in.
`default_nettype none

module text_console_cursor_scroll_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tcsu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tcsu_pkg::COLOR_W-1:0]    i_cfg_data,
    // input transaction
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic [tcsu_pkg::CHAR_W-1:0]     i_character,
    input  wire logic [tcsu_pkg::READ_IDX_W-1:0] i_read_index,
    // result transaction
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [tcsu_pkg::CHAR_W-1:0]          o_cell_character,
    output logic [tcsu_pkg::ATTR_W-1:0]          o_cell_attribute,
    output logic [tcsu_pkg::ROW_W-1:0]           o_cursor_row,
    output logic [tcsu_pkg::COL_W-1:0]           o_cursor_column
);

    tcsu_pkg::t_cmd    w_cmd;
    tcsu_pkg::t_status w_status;

    // config registers always take a write
    assign o_cfg_ready = 1'b1;

    // sequencer: decode, wrap handling, scroll and clear sweeps, result hand-off
    tcsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // cursor, colours, cell store and result register
    tcsu_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_character      (i_character),
        .i_read_index     (i_read_index),
        .i_out_stall      (i_out_stall),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_cell_character (o_cell_character),
        .o_cell_attribute (o_cell_attribute),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_column  (o_cursor_column)
    );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top;
    import tcsu_pkg::*;

    // one input transaction as it goes onto the wires
    typedef struct packed {
        t_op                    op;
        logic [CHAR_W-1:0]      ch;
        logic [READ_IDX_W-1:0]  idx;
    } console_cmd_t;

    // one result transaction: cell seen plus cursor after the operation
    typedef struct packed {
        logic [CHAR_W-1:0]  cell_char;
        logic [ATTR_W-1:0]  cell_attr;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } console_view_t;

    localparam int ITEMS_TOTAL = 1700;
    localparam int PHASES      = 6;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_valid  = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index  = '0;
    logic [COLOR_W-1:0]     i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_opcode     = '0;
    logic [CHAR_W-1:0]      i_character  = '0;
    logic [READ_IDX_W-1:0]  i_read_index = '0;
    logic                   o_out_valid;
    logic                   i_out_stall  = 1'b0;
    logic [CHAR_W-1:0]      o_cell_character;
    logic [ATTR_W-1:0]      o_cell_attribute;
    logic [ROW_W-1:0]       o_cursor_row;
    logic [COL_W-1:0]       o_cursor_column;

    text_console_cursor_scroll_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_character      (i_character),
        .i_read_index     (i_read_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cell_character (o_cell_character),
        .o_cell_attribute (o_cell_attribute),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_column  (o_cursor_column)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shadow of the console: cell store, cursor and colour registers
    // ------------------------------------------------------------------
    logic [CELL_W-1:0]  screen_mirror [CELLS];
    int                 cursor_row_m;
    int                 cursor_col_m;
    logic [COLOR_W-1:0] fg_colour = FG_RESET;
    logic [COLOR_W-1:0] bg_colour = BG_RESET;

    // transactions waiting to be driven, and results still owed by the block
    console_cmd_t       queued_ops [$];
    console_view_t      predicted_outcomes [$];

    int sent_count     = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int mismatch_count = 0;
    int budget_left    = 0;

    // cell in the current colour, background in the high nibble
    function automatic logic [CELL_W-1:0] tinted(input logic [CHAR_W-1:0] ch);
        return {bg_colour, fg_colour, ch};
    endfunction

    // move to column 0 of the next row; from the bottom row the screen scrolls
    // up and the freed row is blanked in the current colour
    function automatic void line_feed();
        int i;
        cursor_col_m = 0;
        if (cursor_row_m < ROWS - 1) begin
            cursor_row_m++;
        end else begin
            for (i = COLS; i < CELLS; i++)
                screen_mirror[i - COLS] = screen_mirror[i];
            for (i = (ROWS - 1) * COLS; i < CELLS; i++)
                screen_mirror[i] = tinted(BLANK_CHAR);
        end
    endfunction

    function automatic console_view_t apply_console_op(input console_cmd_t cmd);
        console_view_t v;
        int i;
        v = '0;
        case (cmd.op)
            OP_PRINT: begin
                if (cmd.ch == NEWLINE_CHAR) begin
                    // newline straight after a full row gives one line feed only
                    line_feed();
                end else begin
                    // pending wrap: column sits at COLS, so feed a line first
                    if (cursor_col_m >= COLS)
                        line_feed();
                    screen_mirror[cursor_row_m * COLS + cursor_col_m] = tinted(cmd.ch);
                    cursor_col_m++;
                end
            end
            OP_CLEAR: begin
                for (i = 0; i < CELLS; i++)
                    screen_mirror[i] = tinted(BLANK_CHAR);
                cursor_row_m = 0;
                cursor_col_m = 0;
            end
            OP_READ: begin
                // an index past the store reads back as zero
                if (int'(cmd.idx) < CELLS) begin
                    v.cell_char = screen_mirror[cmd.idx][CHAR_W-1:0];
                    v.cell_attr = screen_mirror[cmd.idx][CELL_W-1:CHAR_W];
                end
            end
            default: begin
                // unused opcode only reports the cursor
            end
        endcase
        v.row = ROW_W'(cursor_row_m);
        v.col = COL_W'(cursor_col_m);
        return v;
    endfunction

    // mostly no pause, sometimes a few cycles, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 16);
        return $urandom_range(24, 90);
    endfunction

    // ------------------------------------------------------------------
    // input driver: one transaction at a time from queued_ops, payload held
    // steady until taken, random idle cycles between transactions
    // ------------------------------------------------------------------
    int idle_left    = 0;
    int calm_in_left = 0;

    always @(negedge i_clk) begin : drive_commands
        console_cmd_t nxt;
        if (!i_rst_n || (i_in_valid && sent_count != accepted_count)) begin
            // nothing to do: in reset, or the presented transaction is still waiting
        end else if (idle_left > 0) begin
            idle_left--;
            i_in_valid <= 1'b0;
        end else if (queued_ops.size() != 0) begin
            nxt = queued_ops.pop_front();
            i_in_valid   <= 1'b1;
            i_opcode     <= nxt.op;
            i_character  <= nxt.ch;
            i_read_index <= nxt.idx;
            sent_count++;
            // occasional stretches with back-to-back transactions
            if (calm_in_left > 0)
                calm_in_left--;
            else if ($urandom_range(0, 199) == 0)
                calm_in_left = $urandom_range(20, 150);
            idle_left = (calm_in_left > 0) ? 0 : idle_span();
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result side back-pressure, independent of everything else
    // ------------------------------------------------------------------
    int stall_hold    = 0;
    int calm_out_left = 0;

    always @(negedge i_clk) begin : drive_backpressure
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            if (calm_out_left > 0)
                calm_out_left--;
            else if ($urandom_range(0, 149) == 0)
                calm_out_left = $urandom_range(20, 200);
            i_out_stall <= (calm_out_left == 0) && ($urandom_range(0, 99) < 40);
            stall_hold = idle_span();
        end
    end

    // ------------------------------------------------------------------
    // monitor: check the result transaction against the oldest prediction,
    // then predict for any input transaction taken at this edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : score_edge
        console_view_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (predicted_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d with nothing outstanding: char %0h attr %0h row %0d col %0d",
                             result_count, o_cell_character, o_cell_attribute,
                             o_cursor_row, o_cursor_column);
            end else begin
                want = predicted_outcomes.pop_front();
                if (want.cell_char !== o_cell_character || want.cell_attr !== o_cell_attribute ||
                    want.row !== o_cursor_row || want.col !== o_cursor_column) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: exp char %0h attr %0h row %0d col %0d, got char %0h attr %0h row %0d col %0d",
                                 result_count, want.cell_char, want.cell_attr, want.row,
                                 want.col, o_cell_character, o_cell_attribute,
                                 o_cursor_row, o_cursor_column);
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predicted_outcomes.push_back(apply_console_op(
                '{op: t_op'(i_opcode), ch: i_character, idx: i_read_index}));
            accepted_count++;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [READ_IDX_W-1:0] any_index();
        return READ_IDX_W'($urandom_range(0, 2 ** READ_IDX_W - 1));
    endfunction

    function automatic logic [CHAR_W-1:0] any_byte();
        return CHAR_W'($urandom_range(0, 2 ** CHAR_W - 1));
    endfunction

    task automatic queue_op(input t_op op, input logic [CHAR_W-1:0] ch,
                            input logic [READ_IDX_W-1:0] idx);
        if (budget_left > 0) begin
            queued_ops.push_back('{op: op, ch: ch, idx: idx});
            budget_left--;
        end
    endtask

    // reads favour the bottom row, where scrolling leaves its mark
    task automatic queue_read();
        int r;
        logic [READ_IDX_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (r < 8)
            idx = READ_IDX_W'($urandom_range(CELLS, 2 ** READ_IDX_W - 1));
        else if (r < 35)
            idx = READ_IDX_W'($urandom_range((ROWS - 1) * COLS, CELLS - 1));
        else
            idx = READ_IDX_W'($urandom_range(0, CELLS - 1));
        queue_op(OP_READ, any_byte(), idx);
    endtask

    // printable byte: anything but newline
    task automatic queue_glyph();
        logic [CHAR_W-1:0] b;
        b = any_byte();
        if (b == NEWLINE_CHAR)
            b = CHAR_W'($urandom_range(NEWLINE_CHAR + 1, 2 ** CHAR_W - 1));
        queue_op(OP_PRINT, b, any_index());
    endtask

    // a burst of text: lines of mostly short length, some filling a row
    // exactly or running past it, with reads and stray transactions mixed in
    task automatic queue_session();
        int lines, len, k, n, r;
        if ($urandom_range(0, 99) < 35)
            queue_op(OP_CLEAR, any_byte(), any_index());
        lines = $urandom_range(1, 30);
        for (k = 0; k < lines && budget_left > 0; k++) begin
            r = $urandom_range(0, 99);
            if (r < 85)
                len = $urandom_range(0, 3);
            else if (r < 90)
                len = $urandom_range(4, COLS - 1);
            else if (r < 96)
                len = COLS;
            else if (r < 99)
                len = $urandom_range(COLS + 1, 2 * COLS + 10);
            else
                len = 2 * COLS;
            for (n = 0; n < len && budget_left > 0; n++) begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    queue_read();
                else if (r < 8)
                    queue_op(OP_NOP, any_byte(), any_index());
                else if (r == 8)
                    queue_op(OP_PRINT, NEWLINE_CHAR, any_index());
                queue_glyph();
            end
            if ($urandom_range(0, 9) != 0)
                queue_op(OP_PRINT, NEWLINE_CHAR, any_index());
        end
    endtask

    // field extremes, every opcode, out-of-range reads; the store is blanked
    // first so that no read ever sees a cell that was never written
    task automatic queue_directed();
        queue_op(OP_CLEAR, 8'hFF, 11'h7FF);
        queue_op(OP_READ, 8'h00, 11'd0);
        queue_op(OP_READ, 8'hFF, READ_IDX_W'(CELLS - 1));
        queue_op(OP_PRINT, 8'h00, 11'd0);
        queue_op(OP_PRINT, 8'hFF, 11'h7FF);
        queue_op(OP_PRINT, BLANK_CHAR, 11'd0);
        queue_op(OP_PRINT, 8'h41, 11'd0);
        queue_op(OP_READ, 8'h00, 11'd0);
        queue_op(OP_READ, 8'h00, 11'd1);
        queue_op(OP_READ, 8'h00, 11'd3);
        queue_op(OP_PRINT, NEWLINE_CHAR, 11'd0);
        queue_op(OP_PRINT, 8'h80, 11'd0);
        queue_op(OP_PRINT, 8'h7F, 11'd0);
        queue_op(OP_READ, 8'h00, READ_IDX_W'(COLS));
        queue_op(OP_READ, 8'h00, READ_IDX_W'(CELLS));
        queue_op(OP_READ, 8'hFF, 11'h7FF);
        queue_op(OP_NOP, 8'hFF, 11'h7FF);
        queue_op(OP_NOP, 8'h00, 11'd0);
        queue_op(OP_PRINT, NEWLINE_CHAR, 11'd0);
        queue_op(OP_PRINT, NEWLINE_CHAR, 11'd0);
        queue_op(OP_READ, 8'h00, 11'd1024);
        queue_op(OP_READ, 8'h00, READ_IDX_W'(COLS + 1));
    endtask

    // nothing queued, nothing in flight, nothing owed; then a short settle
    task automatic wait_idle();
        while (queued_ops.size() != 0 || sent_count != accepted_count ||
               predicted_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_colour(input t_reg which, input logic [COLOR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        if (which == REG_FG)
            fg_colour = value;
        else
            bg_colour = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // run: reset, then phases under different colour settings
    // ------------------------------------------------------------------
    initial begin : stimulus
        int p;
        cursor_row_m = 0;
        cursor_col_m = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < PHASES; p++) begin
            // first phase runs on the reset colours
            if (p > 0) begin
                wait_idle();
                case (p)
                    1: begin
                        write_colour(REG_FG, '0);
                        write_colour(REG_BG, '0);
                    end
                    2: begin
                        write_colour(REG_FG, '1);
                        write_colour(REG_BG, '1);
                    end
                    3: begin
                        write_colour(REG_BG, '1);
                        write_colour(REG_FG, '0);
                    end
                    default: begin
                        write_colour(REG_FG, COLOR_W'($urandom_range(0, 15)));
                        write_colour(REG_BG, COLOR_W'($urandom_range(0, 15)));
                    end
                endcase
            end
            budget_left = ITEMS_TOTAL / PHASES;
            if (p == 0)
                queue_directed();
            while (budget_left > 0)
                queue_session();
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("text_console_cursor_scroll_unit: match");
        else
            $display("text_console_cursor_scroll_unit: mismatch");
        $finish;
    end

    // watchdog: far beyond any sane run, scrolls and long stalls included
    initial begin : watchdog
        repeat (12_000_000) @(posedge i_clk);
        $display("text_console_cursor_scroll_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tcsu_pkg.sv
hw/rtl/tcsu_ctrl.sv
hw/rtl/tcsu_dpath.sv
hw/rtl/text_console_cursor_scroll_unit.sv
bench/tb_top.sv
